[hw/rtl/lbcb_pkg.sv]
// Shared types and constants for the largest black cross box block.
package lbcb_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int AREA_OUT_W = 16;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  found;
        logic [AREA_OUT_W-1:0] area;
        logic [COORD_W-1:0]    y1;
        logic [COORD_W-1:0]    x1;
        logic [COORD_W-1:0]    y0;
        logic [COORD_W-1:0]    x0;
    } t_box;

    typedef struct packed {
        logic done;
        t_box box;
    } t_scan_stat;

endpackage

[hw/rtl/lbcb_frame_mem.sv]
// One-bit-per-pixel frame store, one write port and one registered read port.
module lbcb_frame_mem #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wbit,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rbit
);

    logic r_mem [2**ADDR_W];
    logic r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wbit;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rbit = r_q;

endmodule

[hw/rtl/lbcb_scan.sv]
// Reverse raster scan: run lengths, per-column down-run memory and best-box tracking.
module lbcb_scan #(
    parameter  int MAX_WIDTH  = 256,
    parameter  int MAX_HEIGHT = 256,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int ROW_W  = $clog2(MAX_HEIGHT),
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1),
    localparam int DN_W   = $clog2(MAX_HEIGHT + 1),
    localparam int AREA_W = CNT_W + DN_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CNT_W-1:0]       i_w,
    input  logic [DN_W-1:0]        i_h,
    output logic [ROW_W-1:0]       o_rd_row,
    output logic [COL_W-1:0]       o_rd_col,
    input  logic                   i_rd_bit,
    output lbcb_pkg::t_scan_stat   o_stat
);

    logic [DN_W-1:0] r_down_mem [MAX_WIDTH];
    logic [DN_W-1:0] r_dn_q;

    logic             r_run;
    logic [COL_W-1:0] r_sx;
    logic [ROW_W-1:0] r_sy;

    logic             r_s1_v;
    logic [COL_W-1:0] r_s1_x;
    logic [ROW_W-1:0] r_s1_y;
    logic             r_s1_rs;
    logic             r_s1_fr;
    logic             r_s1_last;
    logic [CNT_W-1:0] r_right;

    logic             r_wb_v;
    logic [COL_W-1:0] r_wb_x;
    logic [DN_W-1:0]  r_wb_d;

    logic              r_s2_v;
    logic              r_s2_last;
    logic [AREA_W-1:0] r_s2_area;
    logic [COL_W-1:0]  r_s2_x0;
    logic [ROW_W-1:0]  r_s2_y0;
    logic [COL_W-1:0]  r_s2_x1;
    logic [ROW_W-1:0]  r_s2_y1;

    logic [AREA_W-1:0] r_best_area;
    logic [COL_W-1:0]  r_best_x0;
    logic [ROW_W-1:0]  r_best_y0;
    logic [COL_W-1:0]  r_best_x1;
    logic [ROW_W-1:0]  r_best_y1;
    logic              r_done;

    logic [CNT_W-1:0] right_cur;
    logic [DN_W-1:0]  dn_cur;
    logic [CNT_W-1:0] n_right;
    logic [DN_W-1:0]  n_down;
    logic             take;

    assign o_rd_row = r_sy;
    assign o_rd_col = r_sx;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_down_mem[r_s1_x] <= n_down;
        end
        r_dn_q <= r_down_mem[r_sx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_sx  <= '0;
            r_sy  <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_sx  <= COL_W'(i_w - 1'b1);
            r_sy  <= ROW_W'(i_h - 1'b1);
        end else if (r_run) begin
            if (r_sx == '0) begin
                r_sx <= COL_W'(i_w - 1'b1);
                if (r_sy == '0) begin
                    r_run <= 1'b0;
                end else begin
                    r_sy <= r_sy - 1'b1;
                end
            end else begin
                r_sx <= r_sx - 1'b1;
            end
        end
    end

    // stage 1: memory data back, run lengths and area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wb_v <= 1'b0;
        end else begin
            r_s1_v <= r_run;
            r_wb_v <= r_s1_v;
        end
        r_s1_x    <= r_sx;
        r_s1_y    <= r_sy;
        r_s1_rs   <= (32'(r_sx) + 32'd1 == 32'(i_w));
        r_s1_fr   <= (32'(r_sy) + 32'd1 == 32'(i_h));
        r_s1_last <= (r_sx == '0) && (r_sy == '0);
        r_wb_x    <= r_s1_x;
        r_wb_d    <= n_down;
        if (r_s1_v) begin
            r_right <= n_right;
        end
    end

    always_comb begin
        right_cur = r_s1_rs ? '0 : r_right;
        if (r_s1_fr) begin
            dn_cur = '0;
        end else if (r_wb_v && (r_wb_x == r_s1_x)) begin
            dn_cur = r_wb_d;
        end else begin
            dn_cur = r_dn_q;
        end
        if (i_rd_bit) begin
            n_right = right_cur + 1'b1;
            n_down  = dn_cur + 1'b1;
        end else begin
            n_right = '0;
            n_down  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_last <= r_s1_last;
        r_s2_area <= i_rd_bit ? AREA_W'(right_cur) * AREA_W'(dn_cur) : '0;
        r_s2_x0   <= r_s1_x;
        r_s2_y0   <= r_s1_y;
        r_s2_x1   <= r_s1_x + COL_W'(right_cur);
        r_s2_y1   <= r_s1_y + ROW_W'(dn_cur);
    end

    // stage 2: keep the best box; >= in reverse order leaves the earliest tie
    assign take = r_s2_v && (r_s2_area != '0) && (r_s2_area >= r_best_area);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_best_area <= '0;
            r_best_x0   <= '0;
            r_best_y0   <= '0;
            r_best_x1   <= '0;
            r_best_y1   <= '0;
        end else if (take) begin
            r_best_area <= r_s2_area;
            r_best_x0   <= r_s2_x0;
            r_best_y0   <= r_s2_y0;
            r_best_x1   <= r_s2_x1;
            r_best_y1   <= r_s2_y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_v && r_s2_last;
        end
    end

    always_comb begin
        o_stat.done      = r_done;
        o_stat.box.x0    = lbcb_pkg::COORD_W'(r_best_x0);
        o_stat.box.y0    = lbcb_pkg::COORD_W'(r_best_y0);
        o_stat.box.x1    = lbcb_pkg::COORD_W'(r_best_x1);
        o_stat.box.y1    = lbcb_pkg::COORD_W'(r_best_y1);
        o_stat.box.found = (r_best_area != '0);
        if (32'(r_best_area) > 32'd65535) begin
            o_stat.box.area = '1;
        end else begin
            o_stat.box.area = lbcb_pkg::AREA_OUT_W'(r_best_area);
        end
    end

endmodule

[hw/rtl/largest_black_cross_box_top.sv]
// Top level: pixel loading, frame control, scan and result register.
//
// Usage:
//   s_axis carries one 8-bit grey pixel per item in raster order; zero is black.
//   The cfg channel writes image_width (index 0) and image_height (index 1),
//   9 bits each; any write to either restarts loading at the first pixel.
//   Write configuration only while the block is idle.
//   Pixels load at one per cycle. After the last pixel of a frame s_axis
//   is held off while the scan runs, one pixel per cycle in reverse raster
//   order, a rate set by the single read port of the frame bit store and
//   the per-column down-run memory.
//   m_axis then presents one item: the box, its area (saturated to 16 bits)
//   and the found flag in tuser.
//   The result sits in an output register, so loading of the next frame
//   starts at once; if the previous result is still not taken when a scan
//   ends, the block waits with s_axis held off until it is.
//   Reset clears control state, sets both dimensions to 256 and starts a
//   new frame; the frame store itself is not cleared.
module largest_black_cross_box_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] pixel
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] box_x0, [15:8] box_y0, [23:16] box_x1, [31:24] box_y1, [47:32] box_area
    output logic [47:0]                    o_m_axis_tdata,
    output logic                           o_m_axis_tuser,   // [0] found
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lbcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbcb_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int DN_W  = $clog2(MAX_HEIGHT + 1);

    lbcb_pkg::t_state     r_state;
    lbcb_pkg::t_state     n_state;
    lbcb_pkg::t_scan_stat scan_stat;
    lbcb_pkg::t_box       r_out_box;
    logic                 r_out_valid;

    logic [lbcb_pkg::DIM_W-1:0] r_cfg_w;
    logic [lbcb_pkg::DIM_W-1:0] r_cfg_h;
    logic [CNT_W-1:0]           w_eff;
    logic [DN_W-1:0]            h_eff;
    logic [COL_W-1:0]           r_ld_col;
    logic [ROW_W-1:0]           r_ld_row;
    logic [ROW_W-1:0]           rd_row;
    logic [COL_W-1:0]           rd_col;
    logic                       rd_bit;

    logic pix_acc;
    logic col_end;
    logic row_end;
    logic cfg_hit;
    logic scan_start;
    logic out_load;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && ((i_cfg_index == lbcb_pkg::CFG_WIDTH) ||
                                     (i_cfg_index == lbcb_pkg::CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= lbcb_pkg::DIM_W'(256);
            r_cfg_h <= lbcb_pkg::DIM_W'(256);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lbcb_pkg::CFG_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_index == lbcb_pkg::CFG_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = DN_W'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = DN_W'(MAX_HEIGHT);
        end else begin
            h_eff = DN_W'(r_cfg_h);
        end
    end

    assign o_s_axis_tready = (r_state == lbcb_pkg::ST_LOAD);
    assign pix_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign col_end = (32'(r_ld_col) + 32'd1 == 32'(w_eff));
    assign row_end = (32'(r_ld_row) + 32'd1 == 32'(h_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_ld_col <= '0;
            r_ld_row <= '0;
        end else if (pix_acc) begin
            if (col_end) begin
                r_ld_col <= '0;
                r_ld_row <= row_end ? '0 : r_ld_row + 1'b1;
            end else begin
                r_ld_col <= r_ld_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbcb_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        scan_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            lbcb_pkg::ST_LOAD: begin
                if (pix_acc && col_end && row_end) begin
                    scan_start = 1'b1;
                    n_state    = lbcb_pkg::ST_SCAN;
                end
            end
            lbcb_pkg::ST_SCAN: begin
                if (scan_stat.done) begin
                    n_state = lbcb_pkg::ST_OUT;
                end
            end
            lbcb_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = lbcb_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = lbcb_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_box <= scan_stat.box;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_box.area, r_out_box.y1, r_out_box.x1,
                              r_out_box.y0, r_out_box.x0};
    assign o_m_axis_tuser  = r_out_box.found;

    lbcb_frame_mem #(
        .ADDR_W (ROW_W + COL_W)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr ({r_ld_row, r_ld_col}),
        .i_wbit  (i_s_axis_tdata == '0),
        .i_raddr ({rd_row, rd_col}),
        .o_rbit  (rd_bit)
    );

    lbcb_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_w      (w_eff),
        .i_h      (h_eff),
        .o_rd_row (rd_row),
        .o_rd_col (rd_col),
        .i_rd_bit (rd_bit),
        .o_stat   (scan_stat)
    );

endmodule

[hw/rtl/lbcb_checker.sv]
// Port-level assertions for the top level, attached by bind.
module lbcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 48'd0)
        else $error("no box found but box fields nonzero");

    a_found_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[47:32] != 16'd0)
        else $error("box found with zero area");

endmodule

bind largest_black_cross_box_top lbcb_checker u_lbcb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/lbcb_box_checker.sv]
// Checker for the largest black cross box block: predicts each box and compares results.
`timescale 1ns / 100ps
module lbcb_box_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [lbcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbcb_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [7:0]                     i_pix_data,
    input  logic                           i_box_valid,
    input  logic                           i_box_ready,
    input  logic [47:0]                    i_box_data,
    input  logic                           i_box_found,
    output int                             o_errors,
    output int                             o_pending
);

    bit                         frame_black [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [lbcb_pkg::DIM_W-1:0] reg_width;
    logic [lbcb_pkg::DIM_W-1:0] reg_height;
    int                         load_col;
    int                         load_row;
    int                         errors = 0;
    lbcb_pkg::t_box             expected_boxes [$];

    function automatic int clamp_dim(input logic [lbcb_pkg::DIM_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    // Store one pixel; on the last pixel of a frame, scan in reverse raster
    // order so that ">=" leaves the earliest of tied start pixels.
    task automatic take_pixel(input logic [7:0] pix);
        int             w;
        int             h;
        int             down_run [0:MAX_WIDTH-1];
        int             right;
        int             area;
        int             bx0;
        int             by0;
        int             bx1;
        int             by1;
        int             barea;
        lbcb_pkg::t_box b;
        w = clamp_dim(reg_width, MAX_WIDTH);
        h = clamp_dim(reg_height, MAX_HEIGHT);
        if (load_col >= w) load_col = 0;
        if (load_row >= h) load_row = 0;
        frame_black[load_row*MAX_WIDTH + load_col] = (pix == 8'd0);
        if (load_col + 1 < w) begin
            load_col++;
            return;
        end
        load_col = 0;
        if (load_row + 1 < h) begin
            load_row++;
            return;
        end
        load_row = 0;

        bx0   = 0;
        by0   = 0;
        bx1   = 0;
        by1   = 0;
        barea = 0;
        for (int x = 0; x < MAX_WIDTH; x++) down_run[x] = 0;
        for (int y = h - 1; y >= 0; y--) begin
            right = 0;
            for (int x = w - 1; x >= 0; x--) begin
                if (frame_black[y*MAX_WIDTH + x]) begin
                    area = right * down_run[x];
                    if (area > 0 && area >= barea) begin
                        barea = area;
                        bx0   = x;
                        by0   = y;
                        bx1   = x + right;
                        by1   = y + down_run[x];
                    end
                    right++;
                    down_run[x]++;
                end else begin
                    right       = 0;
                    down_run[x] = 0;
                end
            end
        end
        b.x0    = lbcb_pkg::COORD_W'(bx0);
        b.y0    = lbcb_pkg::COORD_W'(by0);
        b.x1    = lbcb_pkg::COORD_W'(bx1);
        b.y1    = lbcb_pkg::COORD_W'(by1);
        b.area  = (barea > 65535) ? {lbcb_pkg::AREA_OUT_W{1'b1}} :
                                    lbcb_pkg::AREA_OUT_W'(barea);
        b.found = (barea > 0);
        expected_boxes.push_back(b);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        lbcb_pkg::t_box want;
        if (!i_rst_n) begin
            reg_width  = 9'd256;
            reg_height = 9'd256;
            load_col   = 0;
            load_row   = 0;
            expected_boxes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lbcb_pkg::CFG_WIDTH: begin
                        reg_width = i_cfg_data;
                        load_col  = 0;
                        load_row  = 0;
                    end
                    lbcb_pkg::CFG_HEIGHT: begin
                        reg_height = i_cfg_data;
                        load_col   = 0;
                        load_row   = 0;
                    end
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) take_pixel(i_pix_data);
            if (i_box_valid && i_box_ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("box result with no expected box pending");
                    errors++;
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("box_x0", want.x0, i_box_data[7:0]);
                    check_field("box_y0", want.y0, i_box_data[15:8]);
                    check_field("box_x1", want.x1, i_box_data[23:16]);
                    check_field("box_y1", want.y1, i_box_data[31:24]);
                    check_field("box_area", want.area, i_box_data[47:32]);
                    check_field("found", want.found, i_box_found);
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_boxes.size();
    end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, stimulus and verdict for largest_black_cross_box_top.
`timescale 1ns / 100ps
module tb;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int ITEMS       = 950;
    localparam int HOLD_CYCLES = 2000;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE      = 300;

    localparam logic [lbcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [lbcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           pix_tvalid = 1'b0;
    logic                           pix_tready;
    logic [7:0]                     pix_tdata  = 8'd0;
    logic                           box_tvalid;
    logic                           box_tready = 1'b0;
    logic [47:0]                    box_tdata;
    logic                           box_tuser;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [lbcb_pkg::CFG_IDX_W-1:0] cfg_index  = lbcb_pkg::CFG_WIDTH;
    logic [lbcb_pkg::DIM_W-1:0]     cfg_data   = '0;

    int errors;
    int pending;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int n_sent        = 0;

    largest_black_cross_box_top #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(pix_tvalid),
        .o_s_axis_tready(pix_tready),
        .i_s_axis_tdata (pix_tdata),
        .o_m_axis_tvalid(box_tvalid),
        .i_m_axis_tready(box_tready),
        .o_m_axis_tdata (box_tdata),
        .o_m_axis_tuser (box_tuser),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    lbcb_box_checker #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_pix_valid(pix_tvalid),
        .i_pix_ready(pix_tready),
        .i_pix_data (pix_tdata),
        .i_box_valid(box_tvalid),
        .i_box_ready(box_tready),
        .i_box_data (box_tdata),
        .i_box_found(box_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result sink: random stalls, or one long hold-off when requested.
    initial begin : box_sink
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                box_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                box_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (pix_tvalid && pix_tready) ||
                (box_tvalid && box_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_tvalid <= 1'b0;
            @(negedge clk);
        end
        pix_tvalid <= 1'b1;
        pix_tdata  <= pix;
        @(posedge clk);
        while (!pix_tready) @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int count, input int black_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < black_pct)
                send_pixel(8'd0);
            else
                send_pixel(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic wait_drained();
        pix_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lbcb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbcb_pkg::DIM_W-1:0]     val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input logic [lbcb_pkg::DIM_W-1:0] w_raw,
                            input logic [lbcb_pkg::DIM_W-1:0] h_raw);
        if ($urandom_range(0, 1)) begin
            write_reg(lbcb_pkg::CFG_WIDTH, w_raw);
            write_reg(lbcb_pkg::CFG_HEIGHT, h_raw);
        end else begin
            write_reg(lbcb_pkg::CFG_HEIGHT, h_raw);
            write_reg(lbcb_pkg::CFG_WIDTH, w_raw);
        end
    endtask

    // Register value for an effective size, using the clamped encodings at the ends.
    function automatic logic [lbcb_pkg::DIM_W-1:0] raw_dim(input int eff);
        if (eff == 1 && $urandom_range(0, 1)) return '0;
        if (eff == MAX_W && $urandom_range(0, 1))
            return lbcb_pkg::DIM_W'($urandom_range(257, 511));
        return lbcb_pkg::DIM_W'(eff);
    endfunction

    initial begin : stimulus
        int p;
        int w;
        int h;
        int r;
        int nfr;
        int dens;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1x1 frames: a black pixel alone has no extent, so nothing is found
        set_dims('0, '0);
        send_pixel(8'd0);
        send_pixel(8'd255);

        // 2x2 all black, with writes to unused indices mid-frame
        set_dims(9'd2, 9'd2);
        send_pixel(8'd0);
        write_reg(CFG_SPARE_A, 9'h1FF);
        send_pixel(8'd0);
        send_pixel(8'd0);
        write_reg(CFG_SPARE_B, 9'h000);
        send_pixel(8'd0);

        // partial frame, then restart by a dimension write
        set_dims(9'd3, 9'd1);
        send_pixel(8'd1);

        // tie between two boxes of area 1: the earlier one wins
        set_dims(9'd5, 9'd2);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd0);

        // receiver holds off while 1x1 frames keep coming
        set_dims(raw_dim(1), raw_dim(1));
        hold_req = 1'b1;
        send_pixels(12, 50);
        wait_drained();

        p = 0;
        while (n_sent < ITEMS) begin
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 59; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 59; end
                default: begin src_idle_pct = 27; snk_stall_pct = 27; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 80) begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end else if (r < 85) begin
                w = MAX_W;
                h = 1;
            end else if (r < 90) begin
                w = 1;
                h = MAX_H;
            end else if (r < 95) begin
                w = $urandom_range(9, 32);
                h = $urandom_range(2, 8);
            end else begin
                w = $urandom_range(64, 128);
                h = 2;
            end
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          lbcb_pkg::DIM_W'($urandom_range(0, 511)));
            set_dims(raw_dim(w), raw_dim(h));
            nfr = (w * h > 64) ? 1 : $urandom_range(1, 4);
            repeat (nfr) begin
                case ($urandom_range(0, 4))
                    0: dens = 0;
                    1: dens = 30;
                    2: dens = 60;
                    3: dens = 85;
                    default: dens = 100;
                endcase
                send_pixels(w * h, dens);
            end
            if (w * h > 1 && $urandom_range(0, 6) == 0)
                send_pixels($urandom_range(1, w * h - 1), 50);
            p++;
        end

        pix_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lbcb_pkg.sv
hw/rtl/lbcb_frame_mem.sv
hw/rtl/lbcb_scan.sv
hw/rtl/largest_black_cross_box_top.sv
hw/rtl/lbcb_checker.sv
tb/lbcb_box_checker.sv
tb/tb.sv
